// ===== rtl/ces_pkg.sv =====
`timescale 1ns / 1ps

package ces_pkg;

	// Fixed-point format of the process value and the normal sample
	localparam int VALUE_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int SAMPLE_FRAC = 12;
	localparam int Z_W         = 16;

	// Register widths
	localparam int CFG_W   = 31;
	localparam int DGAIN_W = 18;
	localparam int IDX_W   = 3;

	// Square root: radicand is a non-negative value shifted up by FRAC_BITS
	localparam int ROOT_W = (CFG_W + FRAC_BITS + 1) / 2;
	localparam int RAD_W  = 2 * ROOT_W;

	// Shared multiplier operand and product widths
	localparam int MUL_A_W = VALUE_WIDTH;
	localparam int MUL_B_W = ROOT_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Intermediate widths
	localparam int DMAG_W = VALUE_WIDTH;
	localparam int T_W    = CFG_W + ROOT_W - FRAC_BITS;
	localparam int T_HI_W = T_W - ROOT_W;
	localparam int SUM_W  = PROD_W - SAMPLE_FRAC + 3;

	// Register map
	typedef enum logic [IDX_W-1:0] {
		REG_DRIFT_GAIN     = 3'd0,
		REG_MEAN_LEVEL     = 3'd1,
		REG_DIFFUSION_GAIN = 3'd2,
		REG_INITIAL_VALUE  = 3'd3,
		REG_BOUNDARY_MODE  = 3'd4
	} reg_idx_t;

	// Boundary handling
	localparam logic MODE_TRUNCATE = 1'b0;
	localparam logic MODE_REFLECT  = 1'b1;

endpackage

// ===== rtl/ces_isqrt.sv =====
`timescale 1ns / 1ps

// Restoring integer square root, one result bit per cycle
module ces_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ces_pkg::RAD_W-1:0]     radicand,
	output logic                          busy,
	output logic [ces_pkg::ROOT_W-1:0]    root
);
	import ces_pkg::*;

	localparam int REM_W = ROOT_W + 2;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;

	logic [REM_W+1:0]  pre;
	logic [REM_W+1:0]  trial;
	logic [REM_W+1:0]  diff;
	logic              ge;

	// Bring down the next bit pair and try the next root bit
	always_comb begin
		pre   = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		diff  = pre - trial;
		ge    = (pre >= trial);
	end

	// Iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(ROOT_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Remainder, root and radicand shift
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? diff[REM_W-1:0] : pre[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign busy = (cnt_q != '0);
	assign root = root_q;

endmodule

// ===== rtl/ces_mul.sv =====
`timescale 1ns / 1ps

// Shared unsigned multiplier with registered product
module ces_mul (
	input  logic                          clk,
	input  logic [ces_pkg::MUL_A_W-1:0]   a,
	input  logic [ces_pkg::MUL_B_W-1:0]   b,
	output logic [ces_pkg::PROD_W-1:0]    p
);
	import ces_pkg::*;

	logic [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign p = p_q;

endmodule

// ===== rtl/cir_euler_step_top.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Fields (low bit up)                   Request taken when
// s_*       in   tdata: normal_sample[15:0]             s_tvalid & s_tready
//                tuser: path_start
// m_*       out  tdata: next_value[31:0]                m_tvalid & m_tready
// cfg_*     in   index / data, one register per write    cfg_we
//
// Each request runs through the sequencer states from acceptance to the result
// register; the bit-serial square root starts at acceptance, and the shared
// multiplier computes four products around it.
// s_tready is high only in idle; a held result does not block the next request,
// but a finished step waits until the output register is free.
// arst_n clears the state, configuration, output register and current value to zero; datapath registers are not reset.
module cir_euler_step_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// slave stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [ces_pkg::Z_W-1:0]           s_tdata,  // normal_sample[15:0]
	input  logic                              s_tuser,  // path_start
	// master stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [ces_pkg::VALUE_WIDTH-1:0]   m_tdata,  // next_value[31:0]
	// configuration
	input  logic                              cfg_we,
	input  logic [ces_pkg::IDX_W-1:0]         cfg_index,
	input  logic [ces_pkg::CFG_W-1:0]         cfg_data
);
	import ces_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIFF, ST_DABS, ST_DMUL, ST_DSTORE, ST_WSQ, ST_SMUL,
		ST_SSTORE, ST_ZLO, ST_ZHI, ST_ZACC, ST_DIFN, ST_SUM, ST_FIN
	} state_t;

	localparam logic signed [SUM_W-1:0] SAT_HI =
		SUM_W'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

	state_t state_q;

	// configuration registers
	logic [DGAIN_W-1:0] drift_gain_q;
	logic [CFG_W-1:0]   mean_level_q;
	logic [CFG_W-1:0]   diffusion_gain_q;
	logic [CFG_W-1:0]   initial_value_q;
	logic               boundary_mode_q;

	// step state
	logic signed [VALUE_WIDTH-1:0] cur_q;
	logic                          out_valid_q;
	logic [VALUE_WIDTH-1:0]        out_data_q;

	// datapath registers
	logic signed [VALUE_WIDTH-1:0] x_q;
	logic [Z_W-1:0]                zmag_q;
	logic                          zneg_q;
	logic signed [VALUE_WIDTH:0]   d_q;
	logic [DMAG_W-1:0]             dmag_q;
	logic                          dneg_q;
	logic signed [SUM_W-1:0]       drift_q;
	logic [T_W-1:0]                t_q;
	logic [PROD_W-1:0]             acc_q;
	logic signed [SUM_W-1:0]       diff_q;
	logic signed [SUM_W-1:0]       part_q;
	logic signed [SUM_W-1:0]       y_q;

	// shared units
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  prod;
	logic               sq_start;
	logic [RAD_W-1:0]   sq_rad;
	logic               sq_busy;
	logic [ROOT_W-1:0]  sq_root;

	logic                          accept;
	logic signed [VALUE_WIDTH-1:0] x_in;
	logic                          out_free;
	logic [SUM_W-1:0]              drift_mag;
	logic [SUM_W-1:0]              diff_mag;
	logic signed [SUM_W-1:0]       y_abs;
	logic signed [VALUE_WIDTH-1:0] y_sat;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign x_in     = s_tuser ? $signed(VALUE_WIDTH'(initial_value_q)) : cur_q;

	// root of max(0, x) scaled by the fraction bits
	assign sq_start = accept;
	assign sq_rad   = x_in[VALUE_WIDTH-1] ? '0
	                  : RAD_W'({x_in[VALUE_WIDTH-2:0], {FRAC_BITS{1'b0}}});

	ces_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_rad),
		.busy     (sq_busy),
		.root     (sq_root)
	);

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_DMUL: begin
				mul_a = dmag_q;
				mul_b = MUL_B_W'(drift_gain_q);
			end
			ST_SMUL: begin
				mul_a = MUL_A_W'(diffusion_gain_q);
				mul_b = sq_root;
			end
			ST_ZLO: begin
				mul_a = MUL_A_W'(zmag_q);
				mul_b = t_q[ROOT_W-1:0];
			end
			ST_ZHI: begin
				mul_a = MUL_A_W'(zmag_q);
				mul_b = MUL_B_W'(t_q[T_W-1:ROOT_W]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	ces_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// scaled magnitudes, reflection and saturation
	always_comb begin
		drift_mag = SUM_W'(prod[DMAG_W+DGAIN_W-1:FRAC_BITS]);
		diff_mag  = SUM_W'(acc_q[PROD_W-1:SAMPLE_FRAC]);
		y_abs     = (boundary_mode_q == MODE_REFLECT && y_q < 0) ? -y_q : y_q;
		if (y_abs > SAT_HI) begin
			y_sat = SAT_HI[VALUE_WIDTH-1:0];
		end else if (y_abs < SAT_LO) begin
			y_sat = SAT_LO[VALUE_WIDTH-1:0];
		end else begin
			y_sat = y_abs[VALUE_WIDTH-1:0];
		end
	end

	// configuration writes; out-of-range indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drift_gain_q     <= '0;
			mean_level_q     <= '0;
			diffusion_gain_q <= '0;
			initial_value_q  <= '0;
			boundary_mode_q  <= MODE_TRUNCATE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DRIFT_GAIN:     drift_gain_q     <= cfg_data[DGAIN_W-1:0];
				REG_MEAN_LEVEL:     mean_level_q     <= cfg_data;
				REG_DIFFUSION_GAIN: diffusion_gain_q <= cfg_data;
				REG_INITIAL_VALUE:  initial_value_q  <= cfg_data;
				REG_BOUNDARY_MODE:  boundary_mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer, current value and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// output valid: set by a finished step, cleared when taken
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE:   if (accept) state_q <= ST_DIFF;
				ST_DIFF:   state_q <= ST_DABS;
				ST_DABS:   state_q <= ST_DMUL;
				ST_DMUL:   state_q <= ST_DSTORE;
				ST_DSTORE: state_q <= ST_WSQ;
				ST_WSQ:    if (!sq_busy) state_q <= ST_SMUL;
				ST_SMUL:   state_q <= ST_SSTORE;
				ST_SSTORE: state_q <= ST_ZLO;
				ST_ZLO:    state_q <= ST_ZHI;
				ST_ZHI:    state_q <= ST_ZACC;
				ST_ZACC:   state_q <= ST_DIFN;
				ST_DIFN:   state_q <= ST_SUM;
				ST_SUM:    state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						cur_q      <= y_sat;
						out_data_q <= y_sat;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					x_q    <= x_in;
					zneg_q <= s_tdata[Z_W-1];
					zmag_q <= s_tdata[Z_W-1] ? Z_W'(-s_tdata) : s_tdata;
				end
			end
			ST_DIFF: begin
				d_q <= $signed({2'b00, mean_level_q}) - $signed({x_q[VALUE_WIDTH-1], x_q});
			end
			ST_DABS: begin
				dneg_q <= d_q[VALUE_WIDTH];
				dmag_q <= d_q[VALUE_WIDTH] ? DMAG_W'(-d_q) : DMAG_W'(d_q);
			end
			ST_DSTORE: begin
				drift_q <= dneg_q ? -$signed(drift_mag) : $signed(drift_mag);
			end
			ST_SSTORE: begin
				t_q <= prod[FRAC_BITS+T_W-1:FRAC_BITS];
			end
			ST_ZHI: begin
				acc_q <= prod;
			end
			ST_ZACC: begin
				acc_q <= acc_q + {prod[PROD_W-ROOT_W-1:0], {ROOT_W{1'b0}}};
			end
			ST_DIFN: begin
				diff_q <= zneg_q ? -$signed(diff_mag) : $signed(diff_mag);
				part_q <= SUM_W'(x_q) + drift_q;
			end
			ST_SUM: begin
				y_q <= part_q + diff_q;
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import ces_pkg::*;

	localparam int RANDOM_ITEMS = 1100;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int TAIL_CYCLES  = 40;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [Z_W-1:0]         s_tdata   = '0;  // normal_sample[15:0]
	logic                   s_tuser   = 1'b0;  // path_start
	logic                   m_tvalid;
	logic                   m_tready  = 1'b1;
	logic [VALUE_WIDTH-1:0] m_tdata;  // next_value[31:0]
	logic                   cfg_we    = 1'b0;
	logic [IDX_W-1:0]       cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data  = '0;

	cir_euler_step_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor copy of the registers and the process value (all reset to zero)
	longint unsigned gain_drift = 0;
	longint unsigned level_mean = 0;
	longint unsigned gain_diff  = 0;
	longint unsigned level_init = 0;
	logic            mode_bound = MODE_TRUNCATE;
	longint          level_now  = 0;

	logic [VALUE_WIDTH-1:0] level_due[$];
	logic [VALUE_WIDTH-1:0] want_level;

	int          fail_count     = 0;
	int          samples_sent   = 0;
	int          results_seen   = 0;
	int          settings_count = 0;
	int          reflect_count  = 0;
	int unsigned cycle_count    = 0;

	// Idling control for both sides; calm is shared by both
	logic calm        = 1'b0;
	int   lead_gap    = 0;
	logic lead_early  = 1'b0;
	logic sample_held = 1'b0;
	int   rx_stall    = 0;

	function automatic int draw_gap();
		if (calm || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 14);
	endfunction

	// Rough bell shape around zero, with some full-range draws
	function automatic logic [Z_W-1:0] draw_sample();
		int acc;
		if ($urandom_range(0, 7) == 0)
			return Z_W'($urandom());
		acc = 0;
		for (int k = 0; k < 4; k++)
			acc += $urandom_range(0, 8191);
		return Z_W'(acc - 16382);
	endfunction

	// Bit-by-bit floor square root
	function automatic longint unsigned int_root(longint unsigned v);
		longint unsigned r;
		longint unsigned trial;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = r | (64'd1 << b);
			if (trial * trial <= v)
				r = trial;
		end
		return r;
	endfunction

	function automatic longint clamp_level(longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// One Euler step: reload on path start, pull toward the mean, add the noise kick
	function automatic logic [VALUE_WIDTH-1:0] predict_level(logic [Z_W-1:0] z, logic start);
		longint          x;
		longint          offset;
		longint          pull;
		longint          push;
		longint          y;
		longint unsigned off_mag;
		longint unsigned mag;
		longint unsigned root;
		longint unsigned scaled;
		longint unsigned z_mag;
		if (start)
			level_now = clamp_level(longint'(level_init));
		x = level_now;

		offset  = longint'(level_mean) - x;
		off_mag = (offset < 0) ? -offset : offset;
		mag     = (gain_drift * off_mag) >> FRAC_BITS;
		pull    = (offset < 0) ? -longint'(mag) : longint'(mag);

		// negative value has no root: kick is zero
		root   = (x > 0) ? int_root(longint'(x) << FRAC_BITS) : 0;
		scaled = (gain_diff * root) >> FRAC_BITS;
		z_mag  = z[Z_W-1] ? (longint'(1) << Z_W) - longint'(z) : longint'(z);
		mag    = (scaled * z_mag) >> SAMPLE_FRAC;
		push   = z[Z_W-1] ? -longint'(mag) : longint'(mag);

		y = x + pull + push;
		if (mode_bound == MODE_REFLECT && y < 0)
			y = -y;
		level_now = clamp_level(y);
		return level_now[VALUE_WIDTH-1:0];
	endfunction

	task automatic flag_mismatch(input string what, input logic [VALUE_WIDTH-1:0] want,
			input logic [VALUE_WIDTH-1:0] got);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] %s: next_value expected %h, got %h", $time, what, want, got);
	endtask

	// Result checker and receiver stalls
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			results_seen++;
			if (level_due.size() == 0) begin
				flag_mismatch("unexpected result", 'x, m_tdata);
			end else begin
				want_level = level_due.pop_front();
				if (m_tdata !== want_level)
					flag_mismatch("mismatch", want_level, m_tdata);
			end
			rx_stall = draw_gap();
			if (rx_stall > 0)
				m_tready <= 1'b0;
		end else if (m_tvalid && !m_tready) begin
			if (rx_stall == 0)
				m_tready <= 1'b1;
			else
				rx_stall--;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
				level_due.size());
			$display("cir_euler_step_top verification failed");
			$finish;
		end
	end

	// Register write; the predictor copy follows right away since the block is idle
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DRIFT_GAIN:     gain_drift = val[DGAIN_W-1:0];
			REG_MEAN_LEVEL:     level_mean = val;
			REG_DIFFUSION_GAIN: gain_diff  = val;
			REG_INITIAL_VALUE:  level_init = val;
			REG_BOUNDARY_MODE:  mode_bound = val[0];
			default: ;
		endcase
	endtask

	task automatic program_regs(input logic [CFG_W-1:0] dg, ml, dfg, iv, input logic mode);
		write_reg(REG_DRIFT_GAIN, dg);
		write_reg(REG_MEAN_LEVEL, ml);
		write_reg(REG_DIFFUSION_GAIN, dfg);
		write_reg(REG_INITIAL_VALUE, iv);
		write_reg(REG_BOUNDARY_MODE, CFG_W'(mode));
		settings_count++;
		if (mode == MODE_REFLECT)
			reflect_count++;
	endtask

	// Send one sample; the gap for the next one is drawn at acceptance so that
	// a back-to-back request keeps tvalid high
	task automatic send_sample(input logic [Z_W-1:0] z, input logic start);
		if (!lead_early) begin
			do @(posedge clk); while (!s_tready);
		end
		repeat (lead_gap) @(posedge clk);
		s_tvalid    <= 1'b1;
		s_tdata     <= z;
		s_tuser     <= start;
		sample_held = 1'b1;
		do @(posedge clk); while (!s_tready);
		level_due.insert(level_due.size(), predict_level(z, start));
		samples_sent++;
		lead_gap   = draw_gap();
		lead_early = $urandom_range(0, 1);
		if (!(lead_early && lead_gap == 0)) begin
			s_tvalid    <= 1'b0;
			sample_held = 1'b0;
		end
	endtask

	// Wait until every predicted result has been taken
	task automatic settle();
		if (sample_held) begin
			s_tvalid    <= 1'b0;
			sample_held = 1'b0;
		end
		while (level_due.size() != 0)
			@(posedge clk);
	endtask

	// All registers at reset value: zero process stays at zero
	task automatic test_reset_state();
		send_sample(16'h1000, 1'b0);
		send_sample(16'h8000, 1'b1);
	endtask

	// Drift gain masking to 18 bits, unmapped indexes ignored, negative value in truncation
	task automatic test_register_map();
		settle();
		program_regs('1, 31'h0001_0000, '0, 31'h0002_0000, MODE_TRUNCATE);
		for (int i = REG_BOUNDARY_MODE + 1; i < (1 << IDX_W); i++)
			write_reg(IDX_W'(i), '1);
		send_sample(16'h0000, 1'b1);
		send_sample(16'h1000, 1'b0);
	endtask

	// Saturation at both ends from drift and from diffusion, sample extremes
	task automatic test_saturation();
		settle();
		program_regs('0, '0, '1, '1, MODE_TRUNCATE);
		send_sample(16'h7FFF, 1'b1);
		send_sample(16'h8000, 1'b1);
		send_sample(16'h8000, 1'b0);
		send_sample(16'hFFFF, 1'b1);
		send_sample(16'h0001, 1'b1);
		settle();
		program_regs('1, '1, '0, '0, MODE_TRUNCATE);
		send_sample(16'h0000, 1'b1);
		settle();
		program_regs('1, '0, '0, '1, MODE_TRUNCATE);
		send_sample(16'h0000, 1'b1);
	endtask

	// Reflection of a moderate and of a hugely negative sum
	task automatic test_reflection();
		settle();
		program_regs(31'h8000, '0, 31'h1_0000, 31'h1_0000, MODE_REFLECT);
		send_sample(16'hA000, 1'b1);
		send_sample(16'h7FFF, 1'b0);
		settle();
		program_regs('0, '0, '1, '1, MODE_REFLECT);
		send_sample(16'h8000, 1'b1);
	endtask

	// Mode flips mid path without reload; most negative value reflects to the top
	task automatic test_mode_switch();
		settle();
		program_regs('0, '0, '1, '1, MODE_TRUNCATE);
		send_sample(16'h8000, 1'b1);
		settle();
		write_reg(REG_BOUNDARY_MODE, CFG_W'(MODE_REFLECT));
		send_sample(16'h0000, 1'b0);
		send_sample(16'h0800, 1'b0);
		settle();
		write_reg(REG_BOUNDARY_MODE, CFG_W'(MODE_TRUNCATE));
		send_sample(16'h8000, 1'b0);
	endtask

	task automatic program_random();
		logic [CFG_W-1:0] dg;
		logic [CFG_W-1:0] ml;
		logic [CFG_W-1:0] dfg;
		logic [CFG_W-1:0] iv;
		dg  = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom()) : CFG_W'($urandom_range(0, 'h2000));
		ml  = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom())
			: CFG_W'($urandom_range(0, 'h20_0000));
		dfg = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom()) : CFG_W'($urandom_range(0, 'h8000));
		iv  = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom())
			: CFG_W'($urandom_range(0, 'h20_0000));
		program_regs(dg, ml, dfg, iv, 1'($urandom_range(0, 1)));
		if ($urandom_range(0, 4) == 0)
			write_reg(IDX_W'($urandom_range(REG_BOUNDARY_MODE + 1, (1 << IDX_W) - 1)),
				CFG_W'($urandom()));
	endtask

	// Random settings, each followed by a burst of paths; some bursts carry on the old path
	task automatic test_random_paths();
		int   sent_here;
		int   burst;
		logic fresh;
		sent_here = 0;
		while (sent_here < RANDOM_ITEMS) begin
			settle();
			program_random();
			calm  = ($urandom_range(0, 3) == 0);
			burst = $urandom_range(8, 48);
			fresh = ($urandom_range(0, 3) != 0);
			for (int k = 0; k < burst; k++) begin
				send_sample(draw_sample(), (k == 0) ? fresh : ($urandom_range(0, 11) == 0));
				sent_here++;
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_register_map();
		test_saturation();
		test_reflection();
		test_mode_switch();
		test_random_paths();

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (level_due.size() != 0) begin
			fail_count += level_due.size();
			$display("%0d results never arrived", level_due.size());
		end
		$display("Stepped %0d samples under %0d register settings (%0d reflecting)",
			samples_sent, settings_count, reflect_count);
		$display("Checked %0d results, %0d failures", results_seen, fail_count);
		if (fail_count == 0)
			$display("cir_euler_step_top verification clean");
		else
			$display("cir_euler_step_top verification failed");
		$finish;
	end

endmodule
